// ===== rtl/core/sprite_shadow_projection_defines.svh =====
// Assertion macros used by the checker module.
`ifndef SPRITE_SHADOW_PROJECTION_DEFINES_SVH
`define SPRITE_SHADOW_PROJECTION_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define SSP_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is active.
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle that follows a reset cycle.
`define SSP_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // An upper bound on the linear mark index, 255 * 382 + 381, fits in 17 bits for any
    // 8-bit width and height register values.
    localparam int IDX_W   = 17;
    localparam int PADDR_W = 4;

    localparam logic [31:0] OPAQUE_MASK = 32'hFF00_0000;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_COLOR  = 2'd3;

    localparam logic [7:0] SIZE_RESET = 8'd128;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] pixel;
        logic [13:0] read_index;
    } t_in;

    typedef struct packed {
        logic [31:0] shadow_pixel;
        logic [7:0]  shadow_width;
        logic [7:0]  shadow_height;
        logic        out_of_range;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/sprite_shadow_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shadow builder: a clear transaction (and reset) sweeps all STORE_DEPTH
// entries (16384 at the default 128 x 128 size) of the one-bit mark memory
// at one entry per cycle, with the input held off meanwhile. Pixel
// transactions are accepted whenever no sweep runs. A pixel's mark passes an
// index-multiply register and a write register before it reaches the memory,
// so a read that directly follows pixels waits for those writes to land.
// A read returns its result through a result stage and an output register;
// reads stream at one per cycle while the output side keeps up and no marks
// are in flight. Configuration registers sit on the APB port at 0x0 mode,
// 0x4 width, 0x8 height, 0xC shadow color.
module sprite_shadow_projection #(
    parameter int MAX_WIDTH  = ssp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ssp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire ssp_pkg::t_in                 i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output ssp_pkg::t_out                     o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    import ssp_pkg::*;

    localparam int EFF_MAX_W   = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam int EFF_MAX_H   = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
    localparam int PROJ_DEPTH  = (MAX_WIDTH + MAX_HEIGHT / 2) * (MAX_HEIGHT / 2 + 1);
    localparam int COPY_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_DEPTH = (PROJ_DEPTH > COPY_DEPTH) ? PROJ_DEPTH : COPY_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = (EFF_MAX_W > 1) ? $clog2(EFF_MAX_W) : 1;
    localparam int ROW_W       = $clog2(EFF_MAX_H + 1);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // configuration
    logic        r_mode;
    logic [7:0]  r_src_width;
    logic [7:0]  r_src_height;
    logic [31:0] r_color;

    // control
    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_a_valid;
    logic                r_w_valid;
    logic                r_rd_valid;
    logic                r_out_valid;

    // payload
    logic [7:0]          r_a_row;
    logic [8:0]          r_a_col;
    logic [8:0]          r_a_sw;
    logic [ADDR_W-1:0]   r_w_addr;
    logic                r_rd_oor;
    logic [7:0]          r_rd_sw;
    logic [7:0]          r_rd_sh;
    logic [31:0]         r_rd_color;
    t_out                r_out;

    logic [7:0]          w_eff;
    logic [7:0]          h_eff;
    logic [8:0]          sw;
    logic [7:0]          sh;
    logic [IDX_W-1:0]    area;
    logic                rd_oor;
    logic                pipe_busy;
    logic                rd_move;
    logic                acc;
    logic                acc_clear;
    logic                acc_pixel;
    logic                acc_read;
    logic [8:0]          x9;
    logic [8:0]          y9;
    logic [7:0]          y8;
    logic [7:0]          half_gap;
    logic                row_done;
    logic                col_over;
    logic                col_last;
    logic                opaque;
    logic                mark_go;
    logic [7:0]          a_row;
    logic [8:0]          a_col;
    logic [IDX_W-1:0]    a_idx;
    logic                a_in_store;
    logic                clearing;
    logic                ram_rdata;
    logic                cfg_wr;

    // effective size and shadow geometry
    always_comb begin
        if (r_src_width == 8'd0) begin
            w_eff = 8'd1;
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            w_eff = 8'(MAX_WIDTH);
        end else begin
            w_eff = r_src_width;
        end
        if (r_src_height == 8'd0) begin
            h_eff = 8'd1;
        end else if (32'(r_src_height) > MAX_HEIGHT) begin
            h_eff = 8'(MAX_HEIGHT);
        end else begin
            h_eff = r_src_height;
        end
    end

    assign sw   = r_mode ? (9'(w_eff) + 9'(h_eff >> 1)) : 9'(w_eff);
    assign sh   = r_mode ? ((h_eff >> 1) + 8'd1) : h_eff;
    assign area = IDX_W'(sw) * IDX_W'(sh);

    assign rd_oor = (32'(i_in_data.read_index) >= 32'(area))
                 || (32'(i_in_data.read_index) >= STORE_DEPTH);

    // handshake
    assign pipe_busy = r_a_valid || r_w_valid;
    assign rd_move   = r_rd_valid && (!r_out_valid || i_out_ready);

    // reads wait for in-flight marks so they never see a stale entry
    assign o_in_ready = (r_state == ST_RUN)
                     && ((i_in_data.op != OP_READ)
                      || (!pipe_busy && (!r_rd_valid || rd_move)));

    assign acc       = i_in_valid && o_in_ready;
    assign acc_clear = acc && (i_in_data.op == OP_CLEAR);
    assign acc_pixel = acc && (i_in_data.op == OP_PIXEL);
    assign acc_read  = acc && (i_in_data.op == OP_READ);

    // raster position
    assign x9       = 9'(r_col);
    assign y9       = 9'(r_row);
    assign y8       = 8'(r_row);
    assign row_done = y9 >= 9'(h_eff);
    assign col_over = x9 >= 9'(w_eff);
    assign col_last = (x9 + 9'd1) >= 9'(w_eff);
    assign opaque   = (i_in_data.pixel & OPAQUE_MASK) != 32'd0;
    assign mark_go  = acc_pixel && !row_done && !col_over && opaque;

    assign half_gap = (h_eff - y8) >> 1;
    assign a_row    = r_mode ? (y8 - (y8 >> 1)) : y8;
    assign a_col    = r_mode ? (x9 + 9'(half_gap)) : x9;

    assign a_idx      = IDX_W'(r_a_row) * IDX_W'(r_a_sw) + IDX_W'(r_a_col);
    assign a_in_store = 32'(a_idx) < STORE_DEPTH;

    assign clearing = (r_state == ST_CLEAR);

    ssp_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (clearing || r_w_valid),
        .i_waddr (clearing ? r_clr_addr : r_w_addr),
        .i_wdata (!clearing),
        .i_re    (acc_read),
        .i_raddr (ADDR_W'(i_in_data.read_index)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_a_valid   <= 1'b0;
            r_w_valid   <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_a_valid  <= 1'b0;
                    r_w_valid  <= 1'b0;
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (acc_clear) begin
                        // pending marks predate the clear: drop them
                        r_state    <= ST_CLEAR;
                        r_clr_addr <= '0;
                        r_col      <= '0;
                        r_row      <= '0;
                        r_a_valid  <= 1'b0;
                        r_w_valid  <= 1'b0;
                    end else begin
                        r_a_valid <= mark_go;
                        r_w_valid <= r_a_valid && a_in_store;
                        if (acc_pixel && !row_done) begin
                            if (col_over || col_last) begin
                                r_col <= '0;
                                r_row <= r_row + ROW_W'(1);
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase

            if (acc_read) begin
                r_rd_valid <= 1'b1;
            end else if (rd_move) begin
                r_rd_valid <= 1'b0;
            end

            if (rd_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_go) begin
            r_a_row <= a_row;
            r_a_col <= a_col;
            r_a_sw  <= sw;
        end
        r_w_addr <= ADDR_W'(a_idx);
        if (acc_read) begin
            r_rd_oor   <= rd_oor;
            r_rd_sw    <= 8'(sw);
            r_rd_sh    <= sh;
            r_rd_color <= r_color;
        end
        if (rd_move) begin
            r_out.shadow_pixel  <= (!r_rd_oor && ram_rdata) ? r_rd_color : 32'd0;
            r_out.shadow_width  <= r_rd_sw;
            r_out.shadow_height <= r_rd_sh;
            r_out.out_of_range  <= r_rd_oor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_src_width  <= SIZE_RESET;
            r_src_height <= SIZE_RESET;
            r_color      <= 32'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:   r_mode       <= pwdata[0];
                REG_WIDTH:  r_src_width  <= pwdata[7:0];
                REG_HEIGHT: r_src_height <= pwdata[7:0];
                REG_COLOR:  r_color      <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, r_mode};
            REG_WIDTH:  prdata = {24'd0, r_src_width};
            REG_HEIGHT: prdata = {24'd0, r_src_height};
            REG_COLOR:  prdata = r_color;
            default:    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/ssp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ssp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_shadow_projection_defines.svh"

module ssp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire ssp_pkg::t_in                 i_in_data,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire ssp_pkg::t_out                o_out_data
);

    import ssp_pkg::*;

    // an out-of-range read never carries a color
    `SSP_ASSERT_HOLD(a_oor_zero, i_clk, i_rst_n, o_out_valid && o_out_data.out_of_range, o_out_data.shadow_pixel == 32'd0, "out-of-range result with nonzero pixel")

    // a stalled result holds
    `SSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // a clear transaction starts the sweep, which blocks the input
    `SSP_ASSERT_NEXT(a_clear_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.op == OP_CLEAR), !o_in_ready, "input open right after clear")

    // reset empties the output and starts the sweep
    `SSP_ASSERT_AFTER_RESET(a_reset_state, i_clk, i_rst_n, !o_out_valid && !o_in_ready, "bad state after reset")

endmodule

bind sprite_shadow_projection ssp_checker u_ssp_checker (.*);

`default_nettype wire
